@@ sv/bcdafd_pkg.sv @@
// ----------------------------------------------------------------------------
// bcdafd_pkg
// Shared types, constants and helpers for the attitude frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bcdafd_pkg;

    localparam int ANGLE_W = 19;

    // Frame header bytes
    localparam logic [7:0] HDR_BYTE0 = 8'h68;
    localparam logic [7:0] HDR_BYTE1 = 8'h0D;

    // Sign nibble of the first angle byte
    localparam logic [3:0] SIGN_NEG = 4'h1;

    // Byte positions
    localparam logic [3:0] POS_HDR0    = 4'd0;
    localparam logic [3:0] POS_HDR1    = 4'd1;
    localparam logic [3:0] POS_PITCH0  = 4'd4;
    localparam logic [3:0] POS_PITCH1  = 4'd5;
    localparam logic [3:0] POS_PITCH2  = 4'd6;
    localparam logic [3:0] POS_ROLL0   = 4'd7;
    localparam logic [3:0] POS_ROLL1   = 4'd8;
    localparam logic [3:0] POS_ROLL2   = 4'd9;
    localparam logic [3:0] POS_HEAD0   = 4'd10;
    localparam logic [3:0] POS_HEAD1   = 4'd11;
    localparam logic [3:0] POS_HEAD2   = 4'd12;
    localparam logic [3:0] POS_IDLE    = 4'd15;

    // Scale of the hundreds digit and of the whole-degree byte
    localparam logic [ANGLE_W-1:0] SCALE_HUNDREDS = ANGLE_W'(10000);
    localparam logic [ANGLE_W-1:0] SCALE_DEGREES  = ANGLE_W'(100);

    // Field selector within the frame
    localparam logic [1:0] FLD_PITCH = 2'd0;
    localparam logic [1:0] FLD_ROLL  = 2'd1;
    localparam logic [1:0] FLD_HEAD  = 2'd2;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] heading;
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
    } angles_t;

    // Packed BCD byte to binary: hi*10 + lo, i.e. b - 6*hi.
    // Never underflows since b >= 16*hi.
    function automatic logic [7:0] bcd_to_dec(input logic [7:0] b);
        logic [7:0] hi6;
        hi6 = {2'b00, b[7:4], 2'b00} + {3'b000, b[7:4], 1'b0};
        return b - hi6;
    endfunction

endpackage

`default_nettype wire

@@ sv/bcdafd_in_reg.sv @@
// ----------------------------------------------------------------------------
// bcdafd_in_reg
// Input register: holds one received word until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdafd_in_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire bcdafd_pkg::in_word_t din,
    input  wire logic               take,
    output logic                    busy,
    output bcdafd_pkg::in_word_t    dout
);

    logic                 valid_reg;
    logic                 valid_next;
    bcdafd_pkg::in_word_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= din;
        end
    end

    assign busy = valid_reg;
    assign dout = data_reg;

endmodule

`default_nettype wire

@@ sv/bcdafd_parse.sv @@
// ----------------------------------------------------------------------------
// bcdafd_parse
// Frame parser: byte position, header check and BCD angle accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdafd_parse (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire bcdafd_pkg::in_word_t word,
    output logic                      emit,
    output bcdafd_pkg::angles_t       angles
);

    localparam int W = bcdafd_pkg::ANGLE_W;

    logic [3:0]          pos_reg;
    logic [3:0]          pos_next;
    logic                hdr_good_reg;
    logic                hdr_good_next;
    logic                neg_reg;
    logic                neg_next;
    logic signed [W-1:0] pitch_reg;
    logic signed [W-1:0] roll_reg;
    logic signed [W-1:0] head_reg;
    logic signed [W-1:0] pitch_next;
    logic signed [W-1:0] roll_next;
    logic signed [W-1:0] head_next;

    logic [3:0]          pos;
    logic [7:0]          b;
    logic [7:0]          dec;
    logic [1:0]          offset;
    logic [1:0]          field;
    logic                in_field;
    logic signed [W-1:0] cur_sum;
    logic signed [W-1:0] add_sum;
    logic signed [W-1:0] new_sum;

    assign b   = word.rx_byte;
    assign pos = word.frame_start ? bcdafd_pkg::POS_HDR0 : pos_reg;
    assign dec = bcdafd_pkg::bcd_to_dec(b);

    // Which angle and which of its three bytes
    always_comb
    begin
        in_field = 1'b1;
        offset   = 2'd0;
        field    = bcdafd_pkg::FLD_PITCH;
        unique case (pos) inside
            bcdafd_pkg::POS_PITCH0: begin offset = 2'd0; field = bcdafd_pkg::FLD_PITCH; end
            bcdafd_pkg::POS_PITCH1: begin offset = 2'd1; field = bcdafd_pkg::FLD_PITCH; end
            bcdafd_pkg::POS_PITCH2: begin offset = 2'd2; field = bcdafd_pkg::FLD_PITCH; end
            bcdafd_pkg::POS_ROLL0:  begin offset = 2'd0; field = bcdafd_pkg::FLD_ROLL;  end
            bcdafd_pkg::POS_ROLL1:  begin offset = 2'd1; field = bcdafd_pkg::FLD_ROLL;  end
            bcdafd_pkg::POS_ROLL2:  begin offset = 2'd2; field = bcdafd_pkg::FLD_ROLL;  end
            bcdafd_pkg::POS_HEAD0:  begin offset = 2'd0; field = bcdafd_pkg::FLD_HEAD;  end
            bcdafd_pkg::POS_HEAD1:  begin offset = 2'd1; field = bcdafd_pkg::FLD_HEAD;  end
            bcdafd_pkg::POS_HEAD2:  begin offset = 2'd2; field = bcdafd_pkg::FLD_HEAD;  end
            default:                in_field = 1'b0;
        endcase
    end

    always_comb
    begin
        case (field)
            bcdafd_pkg::FLD_ROLL: cur_sum = roll_reg;
            bcdafd_pkg::FLD_HEAD: cur_sum = head_reg;
            default:              cur_sum = pitch_reg;
        endcase
    end

    // At most one constant multiply and one add per byte; negate on the last byte
    always_comb
    begin
        add_sum = '0;
        new_sum = '0;
        case (offset)
            2'd0:
            begin
                new_sum = $signed(W'(b[3:0]) * bcdafd_pkg::SCALE_HUNDREDS);
            end
            2'd1:
            begin
                new_sum = cur_sum + $signed(W'(dec) * bcdafd_pkg::SCALE_DEGREES);
            end
            default:
            begin
                add_sum = cur_sum + $signed(W'(dec));
                new_sum = neg_reg ? -add_sum : add_sum;
            end
        endcase
    end

    always_comb
    begin
        pos_next      = pos_reg;
        hdr_good_next = hdr_good_reg;
        neg_next      = neg_reg;
        pitch_next    = pitch_reg;
        roll_next     = roll_reg;
        head_next     = head_reg;
        if (fire)
        begin
            pos_next = pos;
            if (pos != bcdafd_pkg::POS_IDLE)
            begin
                if (pos == bcdafd_pkg::POS_HDR0)
                begin
                    hdr_good_next = (b == bcdafd_pkg::HDR_BYTE0);
                end
                else if (pos == bcdafd_pkg::POS_HDR1 && b != bcdafd_pkg::HDR_BYTE1)
                begin
                    hdr_good_next = 1'b0;
                end
                if (in_field)
                begin
                    if (offset == 2'd0)
                    begin
                        neg_next = (b[7:4] == bcdafd_pkg::SIGN_NEG);
                    end
                    case (field)
                        bcdafd_pkg::FLD_ROLL: roll_next  = new_sum;
                        bcdafd_pkg::FLD_HEAD: head_next  = new_sum;
                        default:              pitch_next = new_sum;
                    endcase
                end
                pos_next = (pos >= bcdafd_pkg::POS_HEAD2) ? bcdafd_pkg::POS_IDLE
                                                          : pos + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= bcdafd_pkg::POS_IDLE;
            hdr_good_reg <= 1'b0;
            neg_reg      <= 1'b0;
            pitch_reg    <= '0;
            roll_reg     <= '0;
            head_reg     <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            hdr_good_reg <= hdr_good_next;
            neg_reg      <= neg_next;
            pitch_reg    <= pitch_next;
            roll_reg     <= roll_next;
            head_reg     <= head_next;
        end
    end

    assign emit           = fire && pos == bcdafd_pkg::POS_HEAD2 && hdr_good_reg;
    assign angles.pitch   = pitch_reg;
    assign angles.roll    = roll_reg;
    assign angles.heading = new_sum;

    // Positions 13 and 14 are never entered
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= bcdafd_pkg::POS_HEAD2 || pos_reg == bcdafd_pkg::POS_IDLE)
        else $error("byte position out of range");

    // Last angle byte always closes the frame
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        fire && pos >= bcdafd_pkg::POS_HEAD2 |=> pos_reg == bcdafd_pkg::POS_IDLE)
        else $error("frame not closed after last angle byte");

    // Result only on a consumed byte of a valid header
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> fire && hdr_good_reg && pos != bcdafd_pkg::POS_IDLE)
        else $error("result emitted without a valid frame");

endmodule

`default_nettype wire

@@ sv/bcd_attitude_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// bcd_attitude_frame_decoder
// Decodes compass reply frames into pitch, roll and heading.
// ----------------------------------------------------------------------------
// Bytes come in one word per handshake on the slave side, with s_tuser high on
// byte 0 of each frame (a start mid-frame abandons the frame in progress).
// Bytes 0 and 1 must be 0x68 and 0x0D; bytes 4-6, 7-9 and 10-12 carry signed
// BCD angles (first byte: sign nibble high, 1 = negative; hundreds in the low
// nibble; then whole degrees and hundredths). On byte 12 of a good frame one
// word leaves on the master side with all three angles in hundredths of a
// degree, two's complement. The checksum is not checked; bytes beyond 12 and
// bytes with no open frame are dropped. Each byte passes an input register and
// one short step of logic (at most a constant multiply and an add) into the
// angle registers, or on byte 12 into the output register behind m_tvalid,
// so one byte is taken per clock; throughput drops only while the output
// register is held by m_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_attitude_frame_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tuser,   // [0] frame_start
    // master side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata    // [18:0] pitch, [37:19] roll,
                                        // [56:38] heading, [63:57] zero
);

    localparam int W = bcdafd_pkg::ANGLE_W;

    logic                 in_busy;
    logic                 load;
    logic                 fire;
    logic                 emit;
    logic                 out_free;
    bcdafd_pkg::in_word_t in_word;
    bcdafd_pkg::in_word_t held_word;
    bcdafd_pkg::angles_t  angles;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    bcdafd_pkg::angles_t  out_data_reg;

    assign in_word.rx_byte     = s_tdata;
    assign in_word.frame_start = s_tuser;

    // The parser moves only when the output register can take a result
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_busy && out_free;
    assign s_tready = !in_busy || fire;
    assign load     = s_tvalid && s_tready;

    bcdafd_in_reg u_in_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .din   (in_word),
        .take  (fire),
        .busy  (in_busy),
        .dout  (held_word)
    );

    bcdafd_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .word   (held_word),
        .emit   (emit),
        .angles (angles)
    );

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= angles;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_data_reg.heading[W-1:0], out_data_reg.roll[W-1:0],
                       out_data_reg.pitch[W-1:0]};

    // A result never overwrites one still waiting
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !out_valid_reg || m_tready)
        else $error("result overwrote a pending word");

    // A byte held in the input register is never lost
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_busy && !fire |=> in_busy)
        else $error("held input byte dropped");

    // A new result shows up at the output next cycle
    a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> m_tvalid)
        else $error("result not presented");

endmodule

`default_nettype wire

@@ tb/bcd_attitude_frame_decoder_test.sv @@
// ----------------------------------------------------------------------------
// bcd_attitude_frame_decoder_test
// Self-checking bench for the compass attitude frame decoder.
// ----------------------------------------------------------------------------
// A queue of pending byte words is built up front: a short directed opening
// (extreme angles, a byte with no frame open, a trailing byte, a bad header
// abandoned by a fresh start), then random frames, mostly well formed, mixed
// with bad headers, truncated frames and noise. A clocked driver feeds the
// queue to the slave side with random gaps; a clocked block predicts the
// angles of every accepted word and checks each result word against the
// oldest expected one. The master side stalls at random.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_attitude_frame_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    import bcdafd_pkg::*;

    localparam int RANDOM_WORDS = 1450;
    localparam int STALL_LIMIT  = 2000;   // cycles with no word moving on either side
    localparam int TAIL_CYCLES  = 10;     // cycles run on after the last expected result is in

    typedef struct {
        logic [7:0] rx;
        logic       start;
        int         gap;     // idle cycles after this word is taken
        bit         drain;   // hold this word back until all results are in
    } pending_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    pending_word_t pending[$];
    angles_t       expected_angles[$];

    // decoder state as predicted
    logic [3:0]               frm_pos = POS_IDLE;
    logic                     frm_hdr_ok = 1'b0;
    logic signed [ANGLE_W-1:0] acc_pitch = '0;
    logic signed [ANGLE_W-1:0] acc_roll = '0;
    logic signed [ANGLE_W-1:0] acc_head = '0;
    logic                     acc_neg = 1'b0;

    int errors = 0;
    int in_words = 0;
    int issued_words = 0;
    int ignored_words = 0;
    int out_words = 0;
    int drain_pauses = 0;
    int cycle_count = 0;
    int quiet_cycles = 0;
    int idle_left = 0;
    int stall_left = 0;

    bcd_attitude_frame_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // packed BCD pair as hi*10+lo; non-BCD nibbles pass straight through
    function automatic logic [7:0] bcd_value(input logic [7:0] b);
        return b - 8'(6 * b[7:4]);
    endfunction

    task automatic accumulate(inout logic signed [ANGLE_W-1:0] acc,
                              input int offset, input logic [7:0] rx);
        case (offset)
            0:
            begin
                acc_neg = (rx[7:4] == SIGN_NEG);
                acc = ANGLE_W'(int'(rx[3:0]) * 10000);
            end
            1:
            begin
                acc = acc + ANGLE_W'(int'(bcd_value(rx)) * 100);
            end
            default:
            begin
                acc = acc + ANGLE_W'(bcd_value(rx));
                if (acc_neg)
                    acc = -acc;
            end
        endcase
    endtask

    task automatic predict_word(input logic [7:0] rx, input logic start);
        logic [3:0] p;
        angles_t    a;
        if (start)
            frm_pos = POS_HDR0;
        p = frm_pos;
        if (p == POS_IDLE)
        begin
            ignored_words++;
            return;
        end
        if (p == POS_HDR0)
            frm_hdr_ok = (rx == HDR_BYTE0);
        else if (p == POS_HDR1)
        begin
            if (rx != HDR_BYTE1)
                frm_hdr_ok = 1'b0;
        end
        else if (p >= POS_PITCH0 && p <= POS_PITCH2)
            accumulate(acc_pitch, p - POS_PITCH0, rx);
        else if (p >= POS_ROLL0 && p <= POS_ROLL2)
            accumulate(acc_roll, p - POS_ROLL0, rx);
        else if (p >= POS_HEAD0 && p <= POS_HEAD2)
            accumulate(acc_head, p - POS_HEAD0, rx);

        if (p >= POS_HEAD2)
        begin
            frm_pos = POS_IDLE;
            if (p == POS_HEAD2 && frm_hdr_ok)
            begin
                a.pitch   = acc_pitch;
                a.roll    = acc_roll;
                a.heading = acc_head;
                expected_angles.push_back(a);
            end
        end
        else
            frm_pos = p + 4'd1;
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    // mostly back to back, some short gaps, a few long ones; every fifth
    // stretch of 300 words runs with no gaps at all
    function automatic int pick_gap(input int n);
        int r;
        if ((n / 300) % 5 == 4)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic queue_word(input logic [7:0] rx, input logic start, input bit drain);
        pending_word_t w;
        w.rx    = rx;
        w.start = start;
        w.drain = drain;
        w.gap   = pick_gap(pending.size());
        pending.push_back(w);
    endtask

    task automatic queue_frame(input logic [7:0] f [13], input int len, input bit drain);
        for (int i = 0; i < len; i++)
            queue_word(f[i], i == 0, drain && i == 0);
    endtask

    function automatic logic [7:0] rand_bcd();
        if ($urandom_range(9) < 7)
            return {4'($urandom_range(9)), 4'($urandom_range(9))};
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] rand_sign_byte();
        case ($urandom_range(3))
            0, 1:    return {SIGN_NEG, 4'($urandom)};
            2:       return {4'h0, 4'($urandom_range(9))};
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic build_good_frame(output logic [7:0] f [13]);
        f[0] = HDR_BYTE0;
        f[1] = HDR_BYTE1;
        f[2] = 8'($urandom);
        f[3] = 8'($urandom);
        for (int k = 0; k < 3; k++)
        begin
            f[4 + 3*k] = rand_sign_byte();
            f[5 + 3*k] = rand_bcd();
            f[6 + 3*k] = rand_bcd();
        end
    endtask

    // ------------------------------------------------------------------
    // Slave-side driver: next word at the falling edge once the last is taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_words
        pending_word_t w;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_words == issued_words)
        begin
            if (idle_left > 0)
            begin
                idle_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending.size() != 0 &&
                     !(pending[0].drain && expected_angles.size() != 0))
            begin
                w = pending.pop_front();
                s_tdata  <= w.rx;
                s_tuser  <= w.start;
                s_tvalid <= 1'b1;
                issued_words++;
                idle_left = w.gap;
                if (w.drain)
                    drain_pauses++;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Master-side back pressure
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if ((cycle_count / 700) % 4 != 3 && $urandom_range(99) < 20)
                stall_left = ($urandom_range(9) == 0) ? $urandom_range(40, 8)
                                                      : $urandom_range(3, 1);
        end
    end

    // ------------------------------------------------------------------
    // Check result words, then predict from the byte taken at this edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_and_predict
        angles_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                out_words++;
                if (expected_angles.size() == 0)
                begin
                    $error("result word with none expected: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_angles.pop_front();
                    if (m_tdata[ANGLE_W-1:0] !== want.pitch)
                    begin
                        $error("pitch_hundredths: expected %0d, actual %0d", want.pitch,
                               $signed(m_tdata[ANGLE_W-1:0]));
                        errors++;
                    end
                    if (m_tdata[2*ANGLE_W-1:ANGLE_W] !== want.roll)
                    begin
                        $error("roll_hundredths: expected %0d, actual %0d", want.roll,
                               $signed(m_tdata[2*ANGLE_W-1:ANGLE_W]));
                        errors++;
                    end
                    if (m_tdata[3*ANGLE_W-1:2*ANGLE_W] !== want.heading)
                    begin
                        $error("heading_hundredths: expected %0d, actual %0d", want.heading,
                               $signed(m_tdata[3*ANGLE_W-1:2*ANGLE_W]));
                        errors++;
                    end
                    if (m_tdata[63:3*ANGLE_W] !== '0)
                    begin
                        $error("tdata padding: expected 0, actual %h", m_tdata[63:3*ANGLE_W]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                in_words++;
                predict_word(s_tdata, s_tuser);
            end
        end
    end

    // watchdog: nothing moving for too long means the block has hung
    always @(posedge clk)
    begin
        cycle_count++;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL bcd_attitude_frame_decoder");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [7:0] f [13];
        int         frame_words;
        int         r;
        int         len;
        bit         drain;

        // byte with no frame open: dropped
        queue_word(HDR_BYTE0, 1'b0, 1'b0);
        // most negative pitch, most positive roll, negative zero heading
        f = '{HDR_BYTE0, HDR_BYTE1, 8'h00, 8'h00, 8'h1F, 8'hFF, 8'hFF,
              8'h0F, 8'hFF, 8'hFF, 8'h10, 8'h00, 8'h00};
        queue_frame(f, 13, 1'b0);
        queue_word(8'hA5, 1'b0, 1'b0);              // checksum after byte 12: dropped
        // bad second header byte, abandoned by a fresh start
        queue_word(HDR_BYTE0, 1'b1, 1'b0);
        queue_word(8'h0C, 1'b0, 1'b0);
        queue_word(8'h11, 1'b0, 1'b0);
        // zero pitch, negative roll, heading with a sign nibble that is not 1
        f = '{HDR_BYTE0, HDR_BYTE1, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
              8'h19, 8'h99, 8'h99, 8'h35, 8'h90, 8'h00};
        queue_frame(f, 13, 1'b0);

        frame_words = 0;
        while (frame_words < RANDOM_WORDS)
        begin
            build_good_frame(f);
            r = $urandom_range(99);
            drain = (frame_words == 0) || ($urandom_range(49) == 0);
            if (r < 72)
            begin
                queue_frame(f, 13, drain);
                frame_words += 13;
                len = $urandom_range(3);
                for (int i = 0; i < len; i++)
                    queue_word(8'($urandom), 1'b0, 1'b0);
            end
            else if (r < 82)
            begin
                if ($urandom_range(1) == 0)
                    do f[0] = 8'($urandom); while (f[0] == HDR_BYTE0);
                else
                    do f[1] = 8'($urandom); while (f[1] == HDR_BYTE1);
                queue_frame(f, 13, drain);
                frame_words += 13;
            end
            else if (r < 92)
            begin
                len = $urandom_range(12, 1);
                queue_frame(f, len, drain);
                frame_words += len;
            end
            else
            begin
                len = $urandom_range(6, 1);
                for (int i = 0; i < len; i++)
                    queue_word(8'($urandom), $urandom_range(7) == 0, 1'b0);
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || s_tvalid || expected_angles.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d byte words (%0d outside any frame) and %0d angle words,",
                 in_words, ignored_words, out_words);
        $display("with random gaps and stalls on both sides and %0d drain pauses.",
                 drain_pauses);
        if (errors == 0)
            $display("PASS bcd_attitude_frame_decoder");
        else
            $display("FAIL bcd_attitude_frame_decoder");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
sv/bcdafd_pkg.sv
sv/bcdafd_in_reg.sv
sv/bcdafd_parse.sv
sv/bcd_attitude_frame_decoder.sv
tb/bcd_attitude_frame_decoder_test.sv
